// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/tldn_pkg.sv -----
// ----------------------------------------------------------------------------
// tldn_pkg
// Types and constants of the day/night traffic light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tldn_pkg;

  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int LAMP_W    = 3;

  localparam logic [LAMP_W-1:0] LAMP_OFF    = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_RED    = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_GREEN  = 3'b100;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  localparam logic [CNT_W-1:0] GREEN_RST = 8'd16;
  localparam logic [CNT_W-1:0] YELLOW_RST = 8'd6;
  localparam logic [CNT_W-1:0] BLINK_RST = 8'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GREEN  = 2'd0,
    REG_YELLOW = 2'd1,
    REG_BLINK  = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_GREEN_AC  = 5'b00001,
    PH_YELLOW_AC = 5'b00010,
    PH_GREEN_BD  = 5'b00100,
    PH_YELLOW_BD = 5'b01000,
    PH_NIGHT     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] green_ticks;
    logic [CNT_W-1:0] yellow_ticks;
    logic [CNT_W-1:0] blink_ticks;
  } timing_cfg_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamps_a;
    logic [LAMP_W-1:0] lamps_b;
    logic [LAMP_W-1:0] lamps_c;
    logic [LAMP_W-1:0] lamps_d;
    logic              night_active;
  } lamp_out_t;

  // A zero duration counts as one tick.
  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    at_least_one = (v == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tldn_seq.sv -----
// ----------------------------------------------------------------------------
// tldn_seq
// Phase sequencer, button debounce and lamp decode; advances once per request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tldn_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  button_level,
  input  wire tldn_pkg::timing_cfg_t cfg,
  output tldn_pkg::lamp_out_t        lamps
);
  import tldn_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic             req_day_r, req_day_nxt;
  logic             blink_on_r, blink_on_nxt;
  logic             held_r, held_nxt;
  logic             pending_r, pending_nxt;

  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt_inc;
  logic [LAMP_W-1:0] ac, bd;
  logic             night;

  assign night = (phase_r == PH_NIGHT);

  // lamps shown during this request (state before update)
  always_comb begin
    ac = LAMP_OFF;
    bd = LAMP_OFF;
    case (phase_r)
      PH_GREEN_AC: begin
        ac = LAMP_GREEN;
        bd = LAMP_RED;
      end
      PH_YELLOW_AC: begin
        ac = LAMP_GREEN | LAMP_YELLOW;
        bd = LAMP_RED | LAMP_YELLOW;
      end
      PH_GREEN_BD: begin
        ac = LAMP_RED;
        bd = LAMP_GREEN;
      end
      PH_YELLOW_BD: begin
        ac = LAMP_RED | LAMP_YELLOW;
        bd = LAMP_GREEN | LAMP_YELLOW;
      end
      PH_NIGHT: begin
        ac = blink_on_r ? LAMP_YELLOW : LAMP_OFF;
        bd = ac;
      end
      default: begin
        ac = LAMP_OFF;
        bd = LAMP_OFF;
      end
    endcase
  end

  assign lamps.lamps_a      = ac;
  assign lamps.lamps_b      = bd;
  assign lamps.lamps_c      = ac;
  assign lamps.lamps_d      = bd;
  assign lamps.night_active = night;

  // button debounce: two pressed requests in a row after a release
  always_comb begin
    req_day_nxt = req_day_r;
    held_nxt    = held_r;
    pending_nxt = pending_r;
    if (pending_r) begin
      pending_nxt = 1'b0;
      if (button_level) begin
        req_day_nxt = ~req_day_r;
        held_nxt    = 1'b1;
      end else begin
        held_nxt = 1'b0;
      end
    end else if (button_level) begin
      if (!held_r) begin
        pending_nxt = 1'b1;
      end
    end else begin
      held_nxt = 1'b0;
    end
  end

  always_comb begin
    case (phase_r)
      PH_YELLOW_AC, PH_YELLOW_BD: limit = at_least_one(cfg.yellow_ticks);
      PH_NIGHT:                   limit = at_least_one(cfg.blink_ticks);
      default:                    limit = at_least_one(cfg.green_ticks);
    endcase
  end

  assign cnt_inc = (tick_cnt_r == CNT_MAX) ? tick_cnt_r : tick_cnt_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    tick_cnt_nxt = cnt_inc;
    blink_on_nxt = blink_on_r;
    if (cnt_inc >= limit) begin
      tick_cnt_nxt = '0;
      case (phase_r)
        PH_GREEN_AC:  phase_nxt = PH_YELLOW_AC;
        PH_YELLOW_AC: phase_nxt = PH_GREEN_BD;
        PH_GREEN_BD:  phase_nxt = PH_YELLOW_BD;
        default: begin
          if (req_day_nxt) begin
            phase_nxt    = PH_GREEN_AC;
            blink_on_nxt = 1'b0;
          end else begin
            phase_nxt    = PH_NIGHT;
            blink_on_nxt = ~blink_on_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_GREEN_AC;
      tick_cnt_r <= '0;
      req_day_r  <= 1'b1;
      blink_on_r <= 1'b0;
      held_r     <= 1'b0;
      pending_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      req_day_r  <= req_day_nxt;
      blink_on_r <= blink_on_nxt;
      held_r     <= held_nxt;
      pending_r  <= pending_nxt;
    end
  end

  `ASSERT_CLK(a_day_yellow_clear, !night |-> !blink_on_r, "blink level set during day")
  `ASSERT_CLK(a_debounce_excl, !(pending_r && held_r), "pending and held both set")

endmodule

`default_nettype wire

// ----- rtl/core/traffic_light_day_night_controller_top.sv -----
// ----------------------------------------------------------------------------
// traffic_light_day_night_controller_top
// Four-way traffic light with a timed day cycle and a night yellow blink.
//
// Usage:
//   Input channel (in_valid/in_ready/in_button_level): one request per 50 ms
//   tick with the sampled button level. Result channel (out_valid/out_ready)
//   returns one request per tick: the four lamp sets lit during that tick and
//   night_active. Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data)
//   writes green, yellow and blink durations; cfg_ready is always high and
//   unknown indexes are dropped. Write config only while the block is idle.
//   The result is registered and valid in the cycle after the input is accepted.
//   Throughput: one request per cycle, set by the single output register;
//   in_ready stays high while that register is empty or being drained.
//   When the receiver stalls, the result is held and in_ready drops until
//   out_ready returns. Reset (rst_n low, synchronous) empties the output
//   register, restores default durations and starts day phase A/C green
//   with day mode requested.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module traffic_light_day_night_controller_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           in_button_level,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [tldn_pkg::LAMP_W-1:0]    out_lamps_a,
  output      logic [tldn_pkg::LAMP_W-1:0]    out_lamps_b,
  output      logic [tldn_pkg::LAMP_W-1:0]    out_lamps_c,
  output      logic [tldn_pkg::LAMP_W-1:0]    out_lamps_d,
  output      logic                           out_night_active,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [tldn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tldn_pkg::CNT_W-1:0]     cfg_data
);
  import tldn_pkg::*;

  timing_cfg_t cfg_r;
  lamp_out_t   lamps;
  lamp_out_t   res_r;
  logic        out_valid_r;
  logic        accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_ticks  <= GREEN_RST;
      cfg_r.yellow_ticks <= YELLOW_RST;
      cfg_r.blink_ticks  <= BLINK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GREEN:  cfg_r.green_ticks  <= cfg_data;
        REG_YELLOW: cfg_r.yellow_ticks <= cfg_data;
        REG_BLINK:  cfg_r.blink_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  tldn_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .button_level (in_button_level),
    .cfg          (cfg_r),
    .lamps        (lamps)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= lamps;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lamps_a      = res_r.lamps_a;
  assign out_lamps_b      = res_r.lamps_b;
  assign out_lamps_c      = res_r.lamps_c;
  assign out_lamps_d      = res_r.lamps_d;
  assign out_night_active = res_r.night_active;

  `ASSERT_CLK(a_ready_stall, !in_ready |-> out_valid && !out_ready, "in_ready low without stall")
  `ASSERT_CLK(a_accept_gives_result, accept |=> out_valid, "accepted request produced no result")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the day/night traffic light controller.
// Ticks carrying a button level go in on the input channel. Each lamp result
// is checked field by field against an in-bench model of the phase timer,
// the button debounce and the day/night hand-over. A short table of directed
// ticks and timing writes comes first. It covers the reset lamps, zero and
// maximum durations, a shortened phase, a failed press confirmation, both
// mode changes and a write to an unused index. Random press sequences under
// several timing settings and three idle patterns follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tldn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int NUM_ROWS = 24;
  localparam int SEG_TICKS = 155;

  localparam lamp_out_t LIT_AC_GREEN = '{LAMP_GREEN, LAMP_RED, LAMP_GREEN, LAMP_RED, 1'b0};

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CNT_W-1:0]     data;
    logic                 btn;
    logic                 known;
    lamp_out_t            lit;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_button_level = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic in_ready, out_valid, cfg_ready, out_night_active;
  logic [LAMP_W-1:0] out_lamps_a, out_lamps_b, out_lamps_c, out_lamps_d;

  int send_idle_pct = 18;
  int recv_idle_pct = 59;
  int fault_count = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int night_entries = 0;
  int day_entries = 0;

  lamp_out_t lit_q[$];
  bit press_plan[$];

  // model state
  timing_cfg_t tcfg;
  phase_t      ph;
  logic [CNT_W-1:0] ticks;
  logic day_wanted, day_running, yellow_lit, held, confirm;

  step_row_t dir_tab [NUM_ROWS] = '{
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b1, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b1, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b1, REG_YELLOW, 8'd1,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b1, REG_BLINK,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b1, REG_SPARE,  8'hA5,  1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b1, REG_GREEN,  8'd255, 1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b1, REG_YELLOW, 8'd255, 1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b1, REG_BLINK,  8'd255, 1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b1, 1'b0, LIT_AC_GREEN},
    '{1'b0, REG_GREEN,  8'd0,   1'b0, 1'b0, LIT_AC_GREEN}
  };

  traffic_light_day_night_controller_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lamps_a     (out_lamps_a),
    .out_lamps_b     (out_lamps_b),
    .out_lamps_c     (out_lamps_c),
    .out_lamps_d     (out_lamps_d),
    .out_night_active(out_night_active),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_fault(input string what, input int got, input int want);
    if (fault_count < 30) begin
      $display("%0t ns mismatch %s: got %0d want %0d", $time, what, got, want);
    end
    fault_count++;
  endtask

  // lamps lit during this tick, then the state update for the tick
  task automatic next_lamps(input logic btn, output lamp_out_t res);
    logic [LAMP_W-1:0] ac, bd;
    logic [CNT_W-1:0] limit;
    logic yellow_ph;
    yellow_ph = (ph == PH_YELLOW_AC) || (ph == PH_YELLOW_BD);
    if (day_running) begin
      ac = (ph == PH_GREEN_AC || ph == PH_YELLOW_AC) ? LAMP_GREEN : LAMP_RED;
      bd = (ph == PH_GREEN_AC || ph == PH_YELLOW_AC) ? LAMP_RED : LAMP_GREEN;
      if (yellow_ph) begin
        ac = ac | LAMP_YELLOW;
        bd = bd | LAMP_YELLOW;
      end
    end else begin
      ac = yellow_lit ? LAMP_YELLOW : LAMP_OFF;
      bd = ac;
    end
    res = '{ac, bd, ac, bd, !day_running};

    if (confirm) begin
      confirm = 1'b0;
      if (btn) begin
        day_wanted = !day_wanted;
        held = 1'b1;
      end else begin
        held = 1'b0;
      end
    end else if (btn) begin
      if (!held) confirm = 1'b1;
    end else begin
      held = 1'b0;
    end

    if (day_running) limit = yellow_ph ? tcfg.yellow_ticks : tcfg.green_ticks;
    else limit = tcfg.blink_ticks;
    if (limit == '0) limit = 8'd1;

    if (ticks != CNT_MAX) ticks = ticks + 8'd1;
    if (ticks >= limit) begin
      ticks = '0;
      if (day_running && ph != PH_YELLOW_BD) begin
        case (ph)
          PH_GREEN_AC:  ph = PH_YELLOW_AC;
          PH_YELLOW_AC: ph = PH_GREEN_BD;
          default:      ph = PH_YELLOW_BD;
        endcase
      end else begin
        if (day_wanted && !day_running) day_entries++;
        if (!day_wanted && day_running) night_entries++;
        day_running = day_wanted;
        if (day_running) begin
          ph = PH_GREEN_AC;
          yellow_lit = 1'b0;
        end else begin
          ph = PH_NIGHT;
          yellow_lit = !yellow_lit;
        end
      end
    end
  endtask

  task automatic send_tick(input logic btn, input logic known, input lamp_out_t lit);
    lamp_out_t calc;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_button_level <= btn;
    do @(posedge clk); while (!in_ready);
    next_lamps(btn, calc);
    lit_q.push_back(known ? lit : calc);
    ticks_sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lit_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GREEN:  tcfg.green_ticks = data;
      REG_YELLOW: tcfg.yellow_ticks = data;
      REG_BLINK:  tcfg.blink_ticks = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    lamp_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (lit_q.size() == 0) begin
        report_fault("result with nothing pending", int'(out_lamps_a), 0);
      end else begin
        want = lit_q.pop_front();
        if (out_lamps_a !== want.lamps_a) begin
          report_fault("lamps_a", int'(out_lamps_a), int'(want.lamps_a));
        end
        if (out_lamps_b !== want.lamps_b) begin
          report_fault("lamps_b", int'(out_lamps_b), int'(want.lamps_b));
        end
        if (out_lamps_c !== want.lamps_c) begin
          report_fault("lamps_c", int'(out_lamps_c), int'(want.lamps_c));
        end
        if (out_lamps_d !== want.lamps_d) begin
          report_fault("lamps_d", int'(out_lamps_d), int'(want.lamps_d));
        end
        if (out_night_active !== want.night_active) begin
          report_fault("night_active", int'(out_night_active), int'(want.night_active));
        end
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] g, y, b;
    tcfg = '{GREEN_RST, YELLOW_RST, BLINK_RST};
    ph = PH_GREEN_AC;
    ticks = '0;
    day_wanted = 1'b1;
    day_running = 1'b1;
    yellow_lit = 1'b0;
    held = 1'b0;
    confirm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_tick(dir_tab[i].btn, dir_tab[i].known, dir_tab[i].lit);
    end
    settings_used = 2;

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        1: begin
          g = 8'd255;
          y = 8'd255;
          b = 8'd255;
        end
        2: begin
          g = 8'd0;
          y = 8'd0;
          b = 8'd0;
        end
        default: begin
          g = 8'($urandom_range(1, 6));
          y = 8'($urandom_range(0, 4));
          b = 8'($urandom_range(1, 8));
        end
      endcase
      write_reg(REG_GREEN, g);
      write_reg(REG_YELLOW, y);
      write_reg(REG_BLINK, b);
      if (seg == 3) write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
      settings_used++;

      for (int n = 0; n < SEG_TICKS; n++) begin
        if (press_plan.size() == 0) begin
          if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 5)) press_plan.push_back(1'b0);
            repeat ($urandom_range(2, 6)) press_plan.push_back(1'b1);
          end else begin
            repeat ($urandom_range(1, 4)) press_plan.push_back(1'($urandom_range(0, 1)));
          end
        end
        send_tick(press_plan.pop_front(), 1'b0, LIT_AC_GREEN);
      end
    end

    settle();
    if (lit_q.size() != 0) report_fault("results never returned", 0, lit_q.size());
    $display("Sent %0d ticks, checked %0d results under %0d timing settings.",
             ticks_sent, results_seen, settings_used);
    $display("Night mode entered %0d times, day mode re-entered %0d times.",
             night_entries, day_entries);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/tldn_pkg.sv
rtl/core/tldn_seq.sv
rtl/core/traffic_light_day_night_controller_top.sv
sim/tb.sv
